[hdl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, configuration types and the clamp helper of the PID speed controller.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int DataW    = 16;
  localparam int GainW    = 16;
  localparam int FracW    = 8;
  localparam int LimW     = 15;
  localparam int ErrW     = DataW + 1;
  localparam int ProdW    = GainW + ErrW;
  localparam int IntegW   = LimW + FracW + 2;
  localparam int AccW     = ProdW + 1;
  localparam int SumW     = ProdW + 2;
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  typedef enum logic [2:0] {
    CFG_GAIN_P   = 3'd0,
    CFG_GAIN_I   = 3'd1,
    CFG_GAIN_D   = 3'd2,
    CFG_INT_LIM  = 3'd3,
    CFG_OUT_LIM  = 3'd4,
    CFG_DB_OFF   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [LimW-1:0]         int_lim;
    logic [LimW-1:0]         out_lim;
    logic [LimW-1:0]         db_off;
  } cfg_t;

  typedef struct packed {
    logic                   clr;
    logic signed [ErrW-1:0] err;
    logic signed [ErrW-1:0] dmeas;
  } front_t;

  typedef struct packed {
    logic                    clr;
    logic signed [ProdW-1:0] p_term;
    logic signed [ProdW-1:0] i_incr;
    logic signed [ProdW-1:0] d_prod;
  } prod_t;

  // Clamp a value to plus or minus a limit given in whole output units.
  function automatic logic signed [AccW-1:0] clamp_acc(input logic signed [AccW-1:0] v,
                                                       input logic [LimW-1:0] lim);
    logic signed [AccW-1:0] hi;
    hi = $signed({{(AccW-LimW-FracW){1'b0}}, lim, {FracW{1'b0}}});
    if (v > hi) begin
      return hi;
    end else if (v < -hi) begin
      return -hi;
    end
    return v;
  endfunction

endpackage

[hdl/psc_cfg.sv]
// ----------------------------------------------------------------------------
// psc_cfg
// APB register file holding the gains, limits and deadband offset.
// ----------------------------------------------------------------------------
module psc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [psc_pkg::ApbDataW-1:0]  pwdata,
  output logic [psc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output psc_pkg::cfg_t                 cfg_o,
  output logic                          clamp_req_o
);
  import psc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     clamp_req_q, clamp_req_d;
  logic     wr_en;
  cfg_reg_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = cfg_reg_e'(paddr[ApbAddrW-1:2]);

  always_comb begin
    cfg_d       = cfg_q;
    clamp_req_d = 1'b0;
    if (wr_en) begin
      clamp_req_d = 1'b1;
      case (sel)
        CFG_GAIN_P:  cfg_d.gain_p  = $signed(pwdata[GainW-1:0]);
        CFG_GAIN_I:  cfg_d.gain_i  = $signed(pwdata[GainW-1:0]);
        CFG_GAIN_D:  cfg_d.gain_d  = $signed(pwdata[GainW-1:0]);
        CFG_INT_LIM: cfg_d.int_lim = pwdata[LimW-1:0];
        CFG_OUT_LIM: cfg_d.out_lim = pwdata[LimW-1:0];
        CFG_DB_OFF:  cfg_d.db_off  = pwdata[LimW-1:0];
        default:     clamp_req_d   = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (sel)
      CFG_GAIN_P:  prdata = {{(ApbDataW-GainW){1'b0}}, cfg_q.gain_p};
      CFG_GAIN_I:  prdata = {{(ApbDataW-GainW){1'b0}}, cfg_q.gain_i};
      CFG_GAIN_D:  prdata = {{(ApbDataW-GainW){1'b0}}, cfg_q.gain_d};
      CFG_INT_LIM: prdata = {{(ApbDataW-LimW){1'b0}}, cfg_q.int_lim};
      CFG_OUT_LIM: prdata = {{(ApbDataW-LimW){1'b0}}, cfg_q.out_lim};
      CFG_DB_OFF:  prdata = {{(ApbDataW-LimW){1'b0}}, cfg_q.db_off};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p  <= GainW'(256);
      cfg_q.gain_i  <= '0;
      cfg_q.gain_d  <= '0;
      cfg_q.int_lim <= '1;
      cfg_q.out_lim <= '1;
      cfg_q.db_off  <= '0;
      clamp_req_q   <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      clamp_req_q <= clamp_req_d;
    end
  end

  // The clamp request is registered with the write, so that it sees the new limit.
  assign cfg_o       = cfg_q;
  assign clamp_req_o = clamp_req_q;

endmodule

[hdl/psc_mul.sv]
// ----------------------------------------------------------------------------
// psc_mul
// Input register (error and measurement change) followed by the gain products.
// ----------------------------------------------------------------------------
module psc_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  psc_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic signed [psc_pkg::DataW-1:0]  setpoint_i,
  input  logic signed [psc_pkg::DataW-1:0]  measured_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output psc_pkg::prod_t                    out_o
);
  import psc_pkg::*;

  logic                    f_vld_q, p_vld_q;
  logic                    f_ready, p_ready;
  front_t                  f_q, f_d;
  prod_t                   p_q, p_d;
  logic signed [DataW-1:0] prev_q, prev_d;

  assign p_ready    = !p_vld_q || out_ready_i;
  assign f_ready    = !f_vld_q || p_ready;
  assign in_ready_o = f_ready;

  always_comb begin
    f_d.clr   = req_type_i;
    f_d.err   = ErrW'(setpoint_i) - ErrW'(measured_i);
    f_d.dmeas = ErrW'(measured_i) - ErrW'(prev_q);
    // A clear item restarts the derivative from a measurement of zero.
    prev_d    = req_type_i ? '0 : measured_i;
  end

  always_comb begin
    p_d.clr    = f_q.clr;
    p_d.p_term = ProdW'(cfg_i.gain_p) * ProdW'(f_q.err);
    p_d.i_incr = ProdW'(cfg_i.gain_i) * ProdW'(f_q.err);
    p_d.d_prod = ProdW'(cfg_i.gain_d) * ProdW'(f_q.dmeas);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      prev_q  <= '0;
    end else begin
      if (f_ready) begin
        f_vld_q <= in_valid_i;
      end
      if (p_ready) begin
        p_vld_q <= f_vld_q;
      end
      if (in_valid_i && f_ready) begin
        prev_q <= prev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && f_ready) begin
      f_q <= f_d;
    end
    if (f_vld_q && p_ready) begin
      p_q <= p_d;
    end
  end

  assign out_valid_o = p_vld_q;
  assign out_o       = p_q;

endmodule

[hdl/psc_integ.sv]
// ----------------------------------------------------------------------------
// psc_integ
// Integral accumulator with clamping, and the sum of the three terms.
// ----------------------------------------------------------------------------
module psc_integ (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  psc_pkg::cfg_t                    cfg_i,
  input  logic                             clamp_req_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  psc_pkg::prod_t                   in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [psc_pkg::SumW-1:0]  sum_o
);
  import psc_pkg::*;

  logic                     s_vld_q;
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic signed [IntegW-1:0] integ_q;
  logic signed [AccW-1:0]   acc_raw, acc_new, acc_cfg;
  logic                     fire;

  assign in_ready_o = !s_vld_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    acc_raw = AccW'(integ_q) + AccW'(in_i.i_incr);
    // A zero integral gain holds the integral at zero, as does a clear item.
    if (in_i.clr || (cfg_i.gain_i == '0)) begin
      acc_new = '0;
    end else begin
      acc_new = clamp_acc(acc_raw, cfg_i.int_lim);
    end
    acc_cfg = clamp_acc(AccW'(integ_q), cfg_i.int_lim);
    if (in_i.clr) begin
      sum_d = '0;
    end else begin
      sum_d = SumW'(in_i.p_term) + SumW'(acc_new) - SumW'(in_i.d_prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
      integ_q <= '0;
    end else begin
      if (in_ready_o) begin
        s_vld_q <= in_valid_i;
      end
      if (fire) begin
        integ_q <= acc_new[IntegW-1:0];
      end else if (clamp_req_i) begin
        integ_q <= acc_cfg[IntegW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = s_vld_q;
  assign sum_o       = sum_q;

endmodule

[hdl/psc_out.sv]
// ----------------------------------------------------------------------------
// psc_out
// Deadband offset, scaling to whole units and output clamp into the result
// register.
// ----------------------------------------------------------------------------
module psc_out (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  psc_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [psc_pkg::SumW-1:0]   sum_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [psc_pkg::DataW-1:0]  drive_o
);
  import psc_pkg::*;

  logic                    o_vld_q;
  logic signed [DataW-1:0] drive_q, drive_d;
  logic signed [SumW-1:0]  off, adj, shf, lim;
  logic [LimW-1:0]         lim_eff;

  assign in_ready_o = !o_vld_q || !out_stall_i;

  always_comb begin
    off     = $signed({{(SumW-LimW-FracW){1'b0}}, cfg_i.db_off, {FracW{1'b0}}});
    // An output limit of zero behaves as a limit of one.
    lim_eff = (cfg_i.out_lim == '0) ? LimW'(1) : cfg_i.out_lim;
    lim     = $signed({{(SumW-LimW){1'b0}}, lim_eff});
    if (sum_i > 0) begin
      adj = sum_i + off;
    end else if (sum_i < 0) begin
      adj = sum_i - off;
    end else begin
      adj = sum_i;
    end
    shf = adj >>> FracW;
    if (shf > lim) begin
      drive_d = lim[DataW-1:0];
    end else if (shf < -lim) begin
      drive_d = -lim[DataW-1:0];
    end else begin
      drive_d = shf[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      o_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o = o_vld_q;
  assign drive_o     = drive_q;

endmodule

[hdl/pid_speed_controller.sv]
// ----------------------------------------------------------------------------
// pid_speed_controller: PID controller, derivative on measurement
// Path: a taken transaction moves through the input, product, sum and result registers.
// Throughput: one transaction per cycle while out_stall_i is low, via four registers.
// Reset clears integral and previous measurement; config registers take reset values.
// ----------------------------------------------------------------------------
module pid_speed_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psc_pkg::ApbAddrW-1:0]      paddr,
  input  logic [psc_pkg::ApbDataW-1:0]      pwdata,
  output logic [psc_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic signed [psc_pkg::DataW-1:0]  setpoint_i,
  input  logic signed [psc_pkg::DataW-1:0]  measured_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [psc_pkg::DataW-1:0]  drive_o
);
  import psc_pkg::*;

  cfg_t                   cfg;
  logic                   clamp_req;
  logic                   in_ready;
  logic                   mul_valid, mul_ready;
  prod_t                  mul_data;
  logic                   sum_valid, sum_ready;
  logic signed [SumW-1:0] sum_data;

  assign in_stall_o = !in_ready;

  psc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .clamp_req_o (clamp_req)
  );

  psc_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type_i),
    .setpoint_i  (setpoint_i),
    .measured_i  (measured_i),
    .out_valid_o (mul_valid),
    .out_ready_i (mul_ready),
    .out_o       (mul_data)
  );

  psc_integ u_integ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .clamp_req_i (clamp_req),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mul_ready),
    .in_i        (mul_data),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .sum_o       (sum_data)
  );

  psc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .sum_i       (sum_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o)
  );

`ifndef ASSERT_OFF
  // The input only backs up when the whole pipeline is full behind a stalled result.
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result stage can move");

  // A presented result never exceeds the output limit (a zero limit acts as one).
  a_drive_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((drive_o <= $signed({1'b0, cfg.out_lim}) &&
                      drive_o >= -$signed({1'b0, cfg.out_lim})) ||
                     (cfg.out_lim == '0 &&
                      (drive_o == 16'sd1 || drive_o == 16'sd0 || drive_o == -16'sd1))))
    else $error("drive outside the configured output limit");

  // A result appears only from the stage before it or because it was already held.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(sum_valid))
    else $error("result appeared without a sum behind it");
`endif

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression bench for pid_speed_controller
// Drives control updates and clears through the valid/stall request channel,
// programmes the gains and limits over the APB port between phases, and
// checks every drive value against a cycle-free model of the controller.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psc_pkg::*;

  localparam int ItemsPerPhase = 250;
  localparam int NumPhases     = 7;
  localparam int HoldCycles    = 80;
  localparam int DrainCycles   = 4;
  localparam int TailCycles    = 10;
  localparam int MaxReported   = 10;
  localparam int UnmappedReg   = 6;
  // The longest quiet stretch of a correct run is the receiver hold-off plus a
  // run of random stalls and a few configuration writes. The limit is many
  // times that stretch.
  localparam int QuietLimit    = 2000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrW-1:0]     paddr;
  logic [ApbDataW-1:0]     pwdata;
  logic [ApbDataW-1:0]     prdata;
  logic                    pready;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    req_type_i;
  logic signed [DataW-1:0] setpoint_i;
  logic signed [DataW-1:0] measured_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [DataW-1:0] drive_o;

  // Controller model: holds the register copy, the integral and the last
  // measurement, and the drive values still owed by the block.
  class pid_drive_scoreboard;
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [LimW-1:0]         int_lim;
    logic [LimW-1:0]         out_lim;
    logic [LimW-1:0]         db_off;
    longint                  integ;
    logic signed [DataW-1:0] last_meas;
    logic signed [DataW-1:0] expected_drive[$];
    int                      errors;

    function new();
      gain_p    = 16'sd256;
      gain_i    = '0;
      gain_d    = '0;
      int_lim   = 15'h7FFF;
      out_lim   = 15'h7FFF;
      db_off    = '0;
      integ     = 0;
      last_meas = '0;
      errors    = 0;
    endfunction

    function longint clamp_mag(longint v, longint lim);
      if (v > lim) begin
        return lim;
      end else if (v < -lim) begin
        return -lim;
      end
      return v;
    endfunction

    function void write_reg(int idx, logic [ApbDataW-1:0] val);
      case (idx)
        CFG_GAIN_P: gain_p = val[GainW-1:0];
        CFG_GAIN_I: gain_i = val[GainW-1:0];
        CFG_GAIN_D: gain_d = val[GainW-1:0];
        CFG_INT_LIM: int_lim = val[LimW-1:0];
        CFG_OUT_LIM: out_lim = val[LimW-1:0];
        CFG_DB_OFF: db_off = val[LimW-1:0];
        default: return;
      endcase
      integ = clamp_mag(integ, longint'(int_lim) <<< FracW);
    endfunction

    function void log_request(bit clr, logic signed [DataW-1:0] sp,
                              logic signed [DataW-1:0] ms);
      longint err;
      longint sum;
      longint olim;
      longint drv;
      if (clr) begin
        integ     = 0;
        last_meas = '0;
        expected_drive.push_back('0);
        return;
      end
      err = longint'(sp) - longint'(ms);
      if (gain_i != 0) begin
        integ += longint'(gain_i) * err;
      end else begin
        integ = 0;
      end
      integ = clamp_mag(integ, longint'(int_lim) <<< FracW);
      sum = longint'(gain_p) * err + integ
          - longint'(gain_d) * (longint'(ms) - longint'(last_meas));
      // The deadband offset pushes a nonzero sum further from zero.
      if (sum > 0) begin
        sum += longint'(db_off) <<< FracW;
      end else if (sum < 0) begin
        sum -= longint'(db_off) <<< FracW;
      end
      olim = (out_lim == 0) ? 1 : longint'(out_lim);
      drv  = clamp_mag(sum >>> FracW, olim);
      last_meas = ms;
      expected_drive.push_back(drv[DataW-1:0]);
    endfunction

    function void check_drive(logic signed [DataW-1:0] got);
      logic signed [DataW-1:0] want;
      if (expected_drive.size() == 0) begin
        if (errors < MaxReported) begin
          $display("drive %0d delivered with no request outstanding", got);
        end
        errors++;
        return;
      end
      want = expected_drive.pop_front();
      if (got !== want) begin
        if (errors < MaxReported) begin
          $display("drive mismatch: expected %0d, got %0d", want, got);
        end
        errors++;
      end
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction
  endclass

  pid_drive_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;

  pid_speed_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .setpoint_i (setpoint_i),
    .measured_i (measured_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .drive_o    (drive_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, with an occasional long hold-off so that the
  // pipeline fills and pushes back on the request side.
  initial begin
    int hold_seen;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        for (int n = 0; n < HoldCycles; n++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_drive(drive_o);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni ||
          psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("pid_speed_controller regression: fail");
    $finish;
  end

  task automatic offer_request(input bit clr, input logic signed [DataW-1:0] sp,
                               input logic signed [DataW-1:0] ms);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_type_i <= clr;
    setpoint_i <= sp;
    measured_i <= ms;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.log_request(clr, sp, ms);
  endtask

  // Stop offering and wait until every owed drive value has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input int idx, input logic [ApbDataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(idx * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return '0;
      3: return GainW'($urandom());
      default: return GainW'(int'($urandom_range(1024)) - 512);
    endcase
  endfunction

  function automatic logic [LimW-1:0] pick_limit();
    case ($urandom_range(5))
      0: return '0;
      1: return 15'h7FFF;
      2: return LimW'($urandom());
      default: return LimW'($urandom_range(400));
    endcase
  endfunction

  function automatic logic [LimW-1:0] pick_out_limit();
    case ($urandom_range(5))
      0: return 15'd1;
      1: return 15'h7FFF;
      2: return LimW'($urandom_range(32767, 1));
      default: return LimW'($urandom_range(2000, 1));
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] pick_edge();
    case ($urandom_range(3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  initial begin
    int kind;
    int meas;
    int target;
    logic signed [DataW-1:0] sp;
    logic signed [DataW-1:0] ms;

    sb            = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    req_type_i    = 1'b0;
    setpoint_i    = '0;
    measured_i    = '0;
    meas          = 0;
    target        = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, full-scale error both ways, zero, a clear.
    offer_request(1'b0, 16'sh7FFF, 16'sh8000);
    offer_request(1'b0, 16'sh8000, 16'sh7FFF);
    offer_request(1'b0, 16'sh0000, 16'sh0000);
    offer_request(1'b1, 16'sd1234, -16'sd4321);
    offer_request(1'b0, -16'sd1, 16'sh0000);

    // Extreme gains, the widest offset and a zero output limit.
    drain_results();
    cfg_write(CFG_GAIN_P, 32'h0000_8000);
    cfg_write(CFG_GAIN_I, 32'h0000_7FFF);
    cfg_write(CFG_GAIN_D, 32'h0000_8000);
    cfg_write(CFG_INT_LIM, 32'h0000_7FFF);
    cfg_write(CFG_OUT_LIM, 32'h0000_0000);
    cfg_write(CFG_DB_OFF, 32'h0000_7FFF);
    offer_request(1'b0, 16'sd1, 16'sh0000);
    offer_request(1'b0, 16'sh7FFF, 16'sh8000);
    offer_request(1'b0, 16'sh8000, 16'sh7FFF);
    offer_request(1'b0, 16'sh0000, 16'sh0000);

    // A sum of exactly zero takes no offset; then the integral alone.
    drain_results();
    cfg_write(CFG_GAIN_P, 32'h0000_0000);
    cfg_write(CFG_GAIN_D, 32'h0000_0000);
    cfg_write(CFG_GAIN_I, 32'h0000_0000);
    cfg_write(CFG_OUT_LIM, 32'h0000_7FFF);
    cfg_write(CFG_DB_OFF, 32'd100);
    offer_request(1'b0, 16'sd500, -16'sd7);
    drain_results();
    cfg_write(CFG_GAIN_I, 32'd256);
    offer_request(1'b0, 16'sd1000, 16'sh0000);
    offer_request(1'b0, 16'sd1000, 16'sh0000);

    // Lowering the integral limit clamps the stored integral at once.
    drain_results();
    cfg_write(CFG_INT_LIM, 32'd5);
    offer_request(1'b0, 16'sh0000, 16'sh0000);
    drain_results();
    cfg_write(CFG_GAIN_I, 32'h0000_0000);
    offer_request(1'b0, 16'sd300, 16'sh0000);

    drain_results();
    cfg_write(CFG_INT_LIM, 32'h0000_7FFF);
    cfg_write(CFG_DB_OFF, 32'h0000_0000);
    cfg_write(CFG_GAIN_P, 32'd256);
    cfg_write(CFG_GAIN_D, 32'd256);
    cfg_write(CFG_GAIN_I, 32'h0000_8000);
    offer_request(1'b0, 16'sh8000, 16'sh7FFF);
    offer_request(1'b0, 16'sh7FFF, 16'sh8000);
    offer_request(1'b1, 16'sh7FFF, 16'sh7FFF);
    offer_request(1'b0, 16'sh0000, 16'sh8000);
    drain_results();
    cfg_write(UnmappedReg, 32'hFFFF_FFFF);
    offer_request(1'b0, 16'sd5, 16'sd5);

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      if (phase < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 84;
      end else if (phase < 4) begin
        send_idle_pct = 84;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cfg_write(CFG_GAIN_P, {16'h0, pick_gain()});
      cfg_write(CFG_GAIN_I, {16'h0, pick_gain()});
      cfg_write(CFG_GAIN_D, {16'h0, pick_gain()});
      cfg_write(CFG_INT_LIM, {17'h0, pick_limit()});
      cfg_write(CFG_OUT_LIM, {17'h0, pick_out_limit()});
      cfg_write(CFG_DB_OFF, {17'h0, pick_limit()});

      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ((phase == 4 || phase == 0) && n == 40) begin
          hold_requests++;
        end
        if (phase == 5 && n == 120) begin
          drain_results();
        end
        kind = $urandom_range(99);
        if (kind < 4) begin
          offer_request(1'b1, DataW'($urandom()), DataW'($urandom()));
          meas = 0;
        end else if (kind < 12) begin
          sp = pick_edge();
          ms = pick_edge();
          offer_request(1'b0, sp, ms);
          meas = ms;
        end else if (kind < 40) begin
          sp = DataW'($urandom());
          ms = DataW'($urandom());
          offer_request(1'b0, sp, ms);
          meas = ms;
        end else begin
          // A measurement that wanders in small random steps, and a target that moves now and then.
          if ($urandom_range(19) == 0) begin
            target = int'($urandom_range(4000)) - 2000;
          end
          meas = meas + int'($urandom_range(400)) - 200;
          if (meas > 32767) begin
            meas = 32767;
          end else if (meas < -32768) begin
            meas = -32768;
          end
          offer_request(1'b0, DataW'(target), DataW'(meas));
        end
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pid_speed_controller regression: pass");
    end else begin
      $display("pid_speed_controller regression: fail");
    end
    $finish;
  end

endmodule
